FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the RTL of the download server.
// Each macro expects signals clk and rst_n to exist in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked at every rising clock edge out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: hw/rtl/dds_pkg.sv
// Package for the diagnostic download server: payload types, service and
// reply codes, session codes, register indexes and reset values. No dependencies.
package dds_pkg;

    // Sizes of the request and of a data chunk
    localparam int unsigned MAX_REQUEST = 512;
    localparam int unsigned MAX_CHUNK   = 256;

    // Block length reported in the request-download reply
    localparam logic [15:0] BLOCK_LEN = 16'(MAX_CHUNK + 2);

    localparam logic [31:0] SEED_XOR = 32'hA5A5_A5A5;

    // Service identifiers
    localparam logic [7:0] SID_SESSION  = 8'h10;
    localparam logic [7:0] SID_SECURITY = 8'h27;
    localparam logic [7:0] SID_DOWNLOAD = 8'h34;
    localparam logic [7:0] SID_TRANSFER = 8'h36;
    localparam logic [7:0] SID_EXIT     = 8'h37;

    // Positive reply codes
    localparam logic [7:0] POS_SESSION  = 8'h50;
    localparam logic [7:0] POS_SECURITY = 8'h67;
    localparam logic [7:0] POS_DOWNLOAD = 8'h74;
    localparam logic [7:0] POS_TRANSFER = 8'h76;
    localparam logic [7:0] POS_EXIT     = 8'h77;
    localparam logic [7:0] NEG_REPLY    = 8'h7F;

    // Sub-functions and formats
    localparam logic [7:0] SUB_DEFAULT_SESSION  = 8'h01;
    localparam logic [7:0] SUB_EXTENDED_SESSION = 8'h02;
    localparam logic [7:0] SUB_REQUEST_SEED     = 8'h01;
    localparam logic [7:0] SUB_SEND_KEY         = 8'h02;
    localparam logic [7:0] SUB_NONE             = 8'h00;
    localparam logic [7:0] FMT_ADDR_LEN         = 8'h44;
    localparam logic [7:0] LEN_FORMAT_ID        = 8'h20;

    // Negative response codes
    localparam logic [7:0] NRC_UNKNOWN_SERVICE = 8'h11;
    localparam logic [7:0] NRC_UNKNOWN_SUB     = 8'h12;
    localparam logic [7:0] NRC_BAD_LENGTH      = 8'h13;
    localparam logic [7:0] NRC_WRONG_STATE     = 8'h22;
    localparam logic [7:0] NRC_NO_SEED         = 8'h24;
    localparam logic [7:0] NRC_OUT_OF_RANGE    = 8'h31;
    localparam logic [7:0] NRC_WRONG_KEY       = 8'h35;
    localparam logic [7:0] NRC_FLASH_FAIL      = 8'h72;
    localparam logic [7:0] NRC_WRONG_BLOCK     = 8'h73;

    // Session codes
    localparam logic [2:0] ST_DEFAULT     = 3'd0;
    localparam logic [2:0] ST_EXTENDED    = 3'd1;
    localparam logic [2:0] ST_SEED_SENT   = 3'd2;
    localparam logic [2:0] ST_UNLOCKED    = 3'd3;
    localparam logic [2:0] ST_DOWNLOADING = 3'd4;

    // Erase commands
    localparam logic [1:0] ERASE_NONE = 2'd0;

    // Configuration register indexes
    localparam logic [2:0] REG_ACTIVE_SLOT = 3'd0;
    localparam logic [2:0] REG_SLOT_A_BASE = 3'd1;
    localparam logic [2:0] REG_SLOT_A_CAP  = 3'd2;
    localparam logic [2:0] REG_SLOT_B_BASE = 3'd3;
    localparam logic [2:0] REG_SLOT_B_CAP  = 3'd4;
    localparam logic [2:0] REG_SEC_MASK    = 3'd5;

    // Configuration reset values
    localparam logic [31:0] RST_SLOT_A_CAP = 32'd196608;
    localparam logic [31:0] RST_SLOT_B_CAP = 32'd262144;
    localparam logic [31:0] RST_SEC_MASK   = 32'hDEAD_BEEF;

    // One decoded request item
    typedef struct packed {
        logic [7:0]  service_id;
        logic [7:0]  sub_function;
        logic [7:0]  format_byte;
        logic [31:0] key_value;
        logic [31:0] download_size;
        logic [9:0]  request_length;
        logic [31:0] tick_count;
        logic        flash_ok;
    } req_t;

    // One result item
    typedef struct packed {
        logic [2:0]  reply_length;
        logic [47:0] reply_bytes;
        logic [1:0]  erase_slot;
        logic [31:0] write_address;
        logic [8:0]  write_length;
        logic        meta_write;
        logic        meta_slot;
        logic [31:0] meta_size;
        logic        reset_request;
    } rsp_t;

endpackage

FILE: hw/rtl/dds_if.sv
// Channel interfaces of the download server: request, result and config write.
// Depends on dds_pkg for the payload types.
interface dds_req_if;
    logic          valid;
    logic          ready;
    dds_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dds_rsp_if;
    logic          valid;
    logic          ready;
    dds_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface dds_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

FILE: hw/rtl/diagnostic_download_server.sv
// Path: a request item is accepted into the input register, then moves into the
// result register, which drives the result port.
// Throughput: one item per cycle; the input register and result register both
// advance whenever the result register is empty or being taken.
// Reset (rst_n low, asynchronous): session and download state clear, both stages
// empty, configuration registers return to their default values.
`include "assert_macros.svh"

module diagnostic_download_server (
    input  logic       clk,
    input  logic       rst_n,
    dds_req_if.sink    req,
    dds_rsp_if.source  rsp,
    dds_cfg_if.sink    cfg
);

    // Configuration registers
    logic        active_slot_reg;
    logic [31:0] slot_a_base_reg;
    logic [31:0] slot_a_cap_reg;
    logic [31:0] slot_b_base_reg;
    logic [31:0] slot_b_cap_reg;
    logic [31:0] sec_mask_reg;

    // Session and download state
    logic [2:0]  session_reg,   session_next;
    logic [31:0] seed_reg,      seed_next;
    logic [31:0] image_base_reg, image_base_next;
    logic [31:0] image_size_reg, image_size_next;
    logic [31:0] written_reg,   written_next;
    logic [7:0]  exp_block_reg, exp_block_next;
    logic        target_reg,    target_next;

    // Pipeline stages
    logic          in_valid_reg;
    dds_pkg::req_t in_data_reg;
    logic          out_valid_reg;
    dds_pkg::rsp_t out_data_reg, out_data_next;
    logic          advance;

    // Datapath helpers
    logic [9:0]  data_len;
    logic [10:0] chunk_round;
    logic [31:0] seed_new;
    logic        new_target;
    logic [31:0] new_base;
    logic [31:0] new_cap;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;
    assign cfg.ready = 1'b1;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_slot_reg <= 1'b0;
            slot_a_base_reg <= '0;
            slot_a_cap_reg  <= dds_pkg::RST_SLOT_A_CAP;
            slot_b_base_reg <= '0;
            slot_b_cap_reg  <= dds_pkg::RST_SLOT_B_CAP;
            sec_mask_reg    <= dds_pkg::RST_SEC_MASK;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dds_pkg::REG_ACTIVE_SLOT: active_slot_reg <= cfg.wdata[0];
                dds_pkg::REG_SLOT_A_BASE: slot_a_base_reg <= cfg.wdata;
                dds_pkg::REG_SLOT_A_CAP:  slot_a_cap_reg  <= cfg.wdata;
                dds_pkg::REG_SLOT_B_BASE: slot_b_base_reg <= cfg.wdata;
                dds_pkg::REG_SLOT_B_CAP:  slot_b_cap_reg  <= cfg.wdata;
                dds_pkg::REG_SEC_MASK:    sec_mask_reg    <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // Input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_data_reg <= req.data;
        end
    end

    // Result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Session and download state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg    <= dds_pkg::ST_DEFAULT;
            seed_reg       <= '0;
            image_base_reg <= '0;
            image_size_reg <= '0;
            written_reg    <= '0;
            exp_block_reg  <= '0;
            target_reg     <= 1'b0;
        end
        else if (advance)
        begin
            session_reg    <= session_next;
            seed_reg       <= seed_next;
            image_base_reg <= image_base_next;
            image_size_reg <= image_size_next;
            written_reg    <= written_next;
            exp_block_reg  <= exp_block_next;
            target_reg     <= target_next;
        end
    end

    // Small datapath pieces
    assign data_len    = in_data_reg.request_length - 10'd2;
    assign chunk_round = (11'(data_len) + 11'd3) & ~11'd3;
    assign seed_new    = in_data_reg.tick_count ^ dds_pkg::SEED_XOR;
    assign new_target  = !active_slot_reg;
    assign new_base    = new_target ? slot_b_base_reg : slot_a_base_reg;
    assign new_cap     = new_target ? slot_b_cap_reg : slot_a_cap_reg;

    // Request decode: reply, commands and next state
    always_comb
    begin
        logic [7:0] sid;
        logic [7:0] sub;
        logic [31:0] len;
        logic [47:0] neg_bytes;

        sid       = in_data_reg.service_id;
        sub       = in_data_reg.sub_function;
        len       = 32'(in_data_reg.request_length);
        neg_bytes = {dds_pkg::NEG_REPLY, sid, 32'h0};

        out_data_next   = '0;
        session_next    = session_reg;
        seed_next       = seed_reg;
        image_base_next = image_base_reg;
        image_size_next = image_size_reg;
        written_next    = written_reg;
        exp_block_next  = exp_block_reg;
        target_next     = target_reg;

        if (len >= 32'd1 && len <= dds_pkg::MAX_REQUEST)
        begin
            // negative reply frame by default; code filled in below
            out_data_next.reply_length = 3'd3;
            unique case (sid)
                dds_pkg::SID_SESSION:
                begin
                    if (len < 32'd2)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_BAD_LENGTH, 24'h0};
                    else if (sub == dds_pkg::SUB_DEFAULT_SESSION ||
                             sub == dds_pkg::SUB_EXTENDED_SESSION)
                    begin
                        session_next = (sub == dds_pkg::SUB_DEFAULT_SESSION) ?
                                       dds_pkg::ST_DEFAULT : dds_pkg::ST_EXTENDED;
                        out_data_next.reply_length = 3'd2;
                        out_data_next.reply_bytes  = {dds_pkg::POS_SESSION, sub, 32'h0};
                    end
                    else
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_UNKNOWN_SUB, 24'h0};
                end
                dds_pkg::SID_SECURITY:
                begin
                    if (len < 32'd2)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_BAD_LENGTH, 24'h0};
                    else if (session_reg < dds_pkg::ST_EXTENDED)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_STATE, 24'h0};
                    else if (sub == dds_pkg::SUB_REQUEST_SEED)
                    begin
                        seed_next    = seed_new;
                        session_next = dds_pkg::ST_SEED_SENT;
                        out_data_next.reply_length = 3'd6;
                        out_data_next.reply_bytes  =
                            {dds_pkg::POS_SECURITY, dds_pkg::SUB_REQUEST_SEED, seed_new};
                    end
                    else if (sub == dds_pkg::SUB_SEND_KEY)
                    begin
                        if (session_reg != dds_pkg::ST_SEED_SENT)
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_NO_SEED, 24'h0};
                        else if (len < 32'd6)
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_BAD_LENGTH, 24'h0};
                        else if (in_data_reg.key_value == (seed_reg ^ sec_mask_reg))
                        begin
                            session_next = dds_pkg::ST_UNLOCKED;
                            out_data_next.reply_length = 3'd2;
                            out_data_next.reply_bytes  =
                                {dds_pkg::POS_SECURITY, dds_pkg::SUB_SEND_KEY, 32'h0};
                        end
                        else
                        begin
                            session_next = dds_pkg::ST_EXTENDED;
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_KEY, 24'h0};
                        end
                    end
                    else
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_UNKNOWN_SUB, 24'h0};
                end
                dds_pkg::SID_DOWNLOAD:
                begin
                    if (session_reg != dds_pkg::ST_UNLOCKED)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_STATE, 24'h0};
                    else if (len < 32'd11)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_BAD_LENGTH, 24'h0};
                    else if (sub != dds_pkg::SUB_NONE || in_data_reg.format_byte != dds_pkg::FMT_ADDR_LEN)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_OUT_OF_RANGE, 24'h0};
                    else
                    begin
                        // target fields latch once the format is accepted
                        image_size_next = in_data_reg.download_size;
                        target_next     = new_target;
                        image_base_next = new_base;
                        if (in_data_reg.download_size == 32'd0 ||
                            in_data_reg.download_size > new_cap)
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_OUT_OF_RANGE, 24'h0};
                        else
                        begin
                            out_data_next.erase_slot = {new_target, !new_target};
                            if (!in_data_reg.flash_ok)
                                out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_FLASH_FAIL, 24'h0};
                            else
                            begin
                                written_next   = '0;
                                exp_block_next = 8'd1;
                                session_next   = dds_pkg::ST_DOWNLOADING;
                                out_data_next.reply_length = 3'd4;
                                out_data_next.reply_bytes  =
                                    {dds_pkg::POS_DOWNLOAD, dds_pkg::LEN_FORMAT_ID,
                                     dds_pkg::BLOCK_LEN, 16'h0};
                            end
                        end
                    end
                end
                dds_pkg::SID_TRANSFER:
                begin
                    if (session_reg != dds_pkg::ST_DOWNLOADING)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_STATE, 24'h0};
                    else if (len < 32'd2 || 32'(data_len) > dds_pkg::MAX_CHUNK)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_BAD_LENGTH, 24'h0};
                    else if (sub != exp_block_reg)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_BLOCK, 24'h0};
                    else
                    begin
                        out_data_next.write_address = image_base_reg + written_reg;
                        out_data_next.write_length  = chunk_round[8:0];
                        if (!in_data_reg.flash_ok)
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_FLASH_FAIL, 24'h0};
                        else
                        begin
                            written_next   = written_reg + 32'(data_len);
                            exp_block_next = exp_block_reg + 8'd1;
                            out_data_next.reply_length = 3'd2;
                            out_data_next.reply_bytes  = {dds_pkg::POS_TRANSFER, sub, 32'h0};
                        end
                    end
                end
                dds_pkg::SID_EXIT:
                begin
                    if (session_reg != dds_pkg::ST_DOWNLOADING)
                        out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_WRONG_STATE, 24'h0};
                    else
                    begin
                        out_data_next.meta_write = 1'b1;
                        out_data_next.meta_slot  = target_reg;
                        out_data_next.meta_size  = image_size_reg;
                        if (!in_data_reg.flash_ok)
                            out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_FLASH_FAIL, 24'h0};
                        else
                        begin
                            // system resets after this reply: all state back to idle
                            out_data_next.reply_length  = 3'd1;
                            out_data_next.reply_bytes   = {dds_pkg::POS_EXIT, 40'h0};
                            out_data_next.reset_request = 1'b1;
                            session_next    = dds_pkg::ST_DEFAULT;
                            seed_next       = '0;
                            image_base_next = '0;
                            image_size_next = '0;
                            written_next    = '0;
                            exp_block_next  = '0;
                            target_next     = 1'b0;
                        end
                    end
                end
                default:
                    out_data_next.reply_bytes = neg_bytes | {16'h0, dds_pkg::NRC_UNKNOWN_SERVICE, 24'h0};
            endcase
        end
    end

    // Checks on the stage handshake and the download state
    `ASSERT_SAME(a_hold_when_full, in_valid_reg && !advance, !req.ready)
    `ASSERT_SAME(a_write_only_downloading, advance && out_data_next.write_length != 9'd0,
                 session_reg == dds_pkg::ST_DOWNLOADING)
    `ASSERT_NEXT(a_download_starts, advance && out_data_next.reply_length == 3'd4,
                 session_reg == dds_pkg::ST_DOWNLOADING && exp_block_reg == 8'd1)
    `ASSERT_NEXT(a_exit_clears, advance && out_data_next.reset_request,
                 session_reg == dds_pkg::ST_DEFAULT && written_reg == 32'd0)

endmodule

FILE: test/diagnostic_download_server_test.sv
// Self-checking testbench for diagnostic_download_server: drives request items,
// predicts every result item in SystemVerilog and compares field by field.
// Depends on dds_pkg, the dds_*_if interfaces and the diagnostic_download_server RTL.
module diagnostic_download_server_test;

    localparam int          PIPE_LATENCY   = 2;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          RANDOM_ITEMS   = 450;
    localparam logic [1:0]  ERASE_SLOT_A   = 2'd1;
    localparam logic [1:0]  ERASE_SLOT_B   = 2'd2;
    localparam logic [7:0]  SID_UNKNOWN    = 8'hFF;

    logic clk;
    logic rst_n;

    dds_req_if req_ch ();
    dds_rsp_if rsp_ch ();
    dds_cfg_if cfg_ch ();

    diagnostic_download_server dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Configuration mirror
    logic        run_slot;
    logic [31:0] a_base;
    logic [31:0] a_cap;
    logic [31:0] b_base;
    logic [31:0] b_cap;
    logic [31:0] key_mask;

    // Session and download state mirror
    logic [2:0]  session_code;
    logic [31:0] seed_word;
    logic [31:0] image_origin;
    logic [31:0] image_bytes;
    logic [31:0] bytes_done;
    logic [7:0]  next_block_no;
    logic        dest_slot;

    dds_pkg::rsp_t pending_replies[$];
    int unsigned   items_sent;
    int            mismatch_count;
    int            idle_cycles;
    int            stall_left;
    bit            steady_flow;

    always #10 clk = ~clk;

    function automatic void clear_session();
        session_code  = dds_pkg::ST_DEFAULT;
        seed_word     = '0;
        image_origin  = '0;
        image_bytes   = '0;
        bytes_done    = '0;
        next_block_no = '0;
        dest_slot     = 1'b0;
    endfunction

    function automatic logic [50:0] refusal(input logic [7:0] sid, input logic [7:0] code);
        return {3'd3, dds_pkg::NEG_REPLY, sid, code, 24'h0};
    endfunction

    // Expected result of one request; updates the state mirror
    function automatic dds_pkg::rsp_t predict_reply(input dds_pkg::req_t r);
        dds_pkg::rsp_t o;
        logic [50:0]   reply;
        logic [7:0]    sid;
        logic [7:0]    sub;
        logic [9:0]    len;
        logic [31:0]   cap;
        logic [9:0]    data_len;
        logic [9:0]    padded;
        o     = '0;
        reply = '0;
        sid   = r.service_id;
        sub   = r.sub_function;
        len   = r.request_length;
        if (len == 10'd0 || len > dds_pkg::MAX_REQUEST)
            return o;
        case (sid)
            dds_pkg::SID_SESSION:
            begin
                if (len < 10'd2)
                    reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                else if (sub == dds_pkg::SUB_DEFAULT_SESSION ||
                         sub == dds_pkg::SUB_EXTENDED_SESSION)
                begin
                    session_code = (sub == dds_pkg::SUB_DEFAULT_SESSION) ?
                                   dds_pkg::ST_DEFAULT : dds_pkg::ST_EXTENDED;
                    reply = {3'd2, dds_pkg::POS_SESSION, sub, 32'h0};
                end
                else
                    reply = refusal(sid, dds_pkg::NRC_UNKNOWN_SUB);
            end
            dds_pkg::SID_SECURITY:
            begin
                if (len < 10'd2)
                    reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                else if (session_code == dds_pkg::ST_DEFAULT)
                    reply = refusal(sid, dds_pkg::NRC_WRONG_STATE);
                else if (sub == dds_pkg::SUB_REQUEST_SEED)
                begin
                    seed_word    = r.tick_count ^ dds_pkg::SEED_XOR;
                    session_code = dds_pkg::ST_SEED_SENT;
                    reply = {3'd6, dds_pkg::POS_SECURITY, dds_pkg::SUB_REQUEST_SEED, seed_word};
                end
                else if (sub == dds_pkg::SUB_SEND_KEY)
                begin
                    if (session_code != dds_pkg::ST_SEED_SENT)
                        reply = refusal(sid, dds_pkg::NRC_NO_SEED);
                    else if (len < 10'd6)
                        reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                    else if (r.key_value == (seed_word ^ key_mask))
                    begin
                        session_code = dds_pkg::ST_UNLOCKED;
                        reply = {3'd2, dds_pkg::POS_SECURITY, dds_pkg::SUB_SEND_KEY, 32'h0};
                    end
                    else
                    begin
                        session_code = dds_pkg::ST_EXTENDED;
                        reply = refusal(sid, dds_pkg::NRC_WRONG_KEY);
                    end
                end
                else
                    reply = refusal(sid, dds_pkg::NRC_UNKNOWN_SUB);
            end
            dds_pkg::SID_DOWNLOAD:
            begin
                if (session_code != dds_pkg::ST_UNLOCKED)
                    reply = refusal(sid, dds_pkg::NRC_WRONG_STATE);
                else if (len < 10'd11)
                    reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                else if (sub != dds_pkg::SUB_NONE || r.format_byte != dds_pkg::FMT_ADDR_LEN)
                    reply = refusal(sid, dds_pkg::NRC_OUT_OF_RANGE);
                else
                begin
                    // target fields latch even when the size check fails
                    image_bytes  = r.download_size;
                    dest_slot    = ~run_slot;
                    image_origin = dest_slot ? b_base : a_base;
                    cap          = dest_slot ? b_cap : a_cap;
                    if (image_bytes == 32'd0 || image_bytes > cap)
                        reply = refusal(sid, dds_pkg::NRC_OUT_OF_RANGE);
                    else
                    begin
                        o.erase_slot = dest_slot ? ERASE_SLOT_B : ERASE_SLOT_A;
                        if (!r.flash_ok)
                            reply = refusal(sid, dds_pkg::NRC_FLASH_FAIL);
                        else
                        begin
                            bytes_done    = '0;
                            next_block_no = 8'd1;
                            session_code  = dds_pkg::ST_DOWNLOADING;
                            reply = {3'd4, dds_pkg::POS_DOWNLOAD, dds_pkg::LEN_FORMAT_ID,
                                     dds_pkg::BLOCK_LEN, 16'h0};
                        end
                    end
                end
            end
            dds_pkg::SID_TRANSFER:
            begin
                data_len = len - 10'd2;
                if (session_code != dds_pkg::ST_DOWNLOADING)
                    reply = refusal(sid, dds_pkg::NRC_WRONG_STATE);
                else if (len < 10'd2)
                    reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                else if (data_len > dds_pkg::MAX_CHUNK)
                    reply = refusal(sid, dds_pkg::NRC_BAD_LENGTH);
                else if (sub != next_block_no)
                    reply = refusal(sid, dds_pkg::NRC_WRONG_BLOCK);
                else
                begin
                    padded = (data_len + 10'd3) & ~10'd3;
                    o.write_address = image_origin + bytes_done;
                    o.write_length  = padded[8:0];
                    if (!r.flash_ok)
                        reply = refusal(sid, dds_pkg::NRC_FLASH_FAIL);
                    else
                    begin
                        bytes_done    = bytes_done + 32'(data_len);
                        next_block_no = next_block_no + 8'd1;
                        reply = {3'd2, dds_pkg::POS_TRANSFER, sub, 32'h0};
                    end
                end
            end
            dds_pkg::SID_EXIT:
            begin
                if (session_code != dds_pkg::ST_DOWNLOADING)
                    reply = refusal(sid, dds_pkg::NRC_WRONG_STATE);
                else
                begin
                    o.meta_write = 1'b1;
                    o.meta_slot  = dest_slot;
                    o.meta_size  = image_bytes;
                    if (!r.flash_ok)
                        reply = refusal(sid, dds_pkg::NRC_FLASH_FAIL);
                    else
                    begin
                        reply = {3'd1, dds_pkg::POS_EXIT, 40'h0};
                        o.reset_request = 1'b1;
                        clear_session();
                    end
                end
            end
            default:
                reply = refusal(sid, dds_pkg::NRC_UNKNOWN_SERVICE);
        endcase
        {o.reply_length, o.reply_bytes} = reply;
        return o;
    endfunction

    // Mostly short pauses, now and then a long one
    function automatic int pick_pause();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls unless the flow is steady
    always @(negedge clk)
    begin
        if (steady_flow)
            rsp_ch.ready <= 1'b1;
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 20)
                stall_left = pick_pause();
        end
    end

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        dds_pkg::rsp_t want;
        dds_pkg::rsp_t got;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got = rsp_ch.data;
            if (pending_replies.size() == 0)
            begin
                $error("result item with no expectation pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                compare_field("reply_length", 64'(want.reply_length), 64'(got.reply_length));
                compare_field("reply_bytes", 64'(want.reply_bytes), 64'(got.reply_bytes));
                compare_field("erase_slot", 64'(want.erase_slot), 64'(got.erase_slot));
                compare_field("write_address", 64'(want.write_address),
                              64'(got.write_address));
                compare_field("write_length", 64'(want.write_length), 64'(got.write_length));
                compare_field("meta_write", 64'(want.meta_write), 64'(got.meta_write));
                compare_field("meta_slot", 64'(want.meta_slot), 64'(got.meta_slot));
                compare_field("meta_size", 64'(want.meta_size), 64'(got.meta_size));
                compare_field("reset_request", 64'(want.reset_request),
                              64'(got.reset_request));
            end
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("** diagnostic_download_server: FAILED **");
                $finish;
            end
        end
    end

    // Send one request item; valid stays high for a back-to-back follower
    task automatic send_request(input dds_pkg::req_t item);
        int gap;
        gap = (steady_flow || $urandom_range(0, 99) < 60) ? 0 : pick_pause();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_ch.valid <= 1'b1;
        req_ch.data  <= item;
        do @(posedge clk); while (!req_ch.ready);
        pending_replies.push_back(predict_reply(item));
        if (item.request_length != 10'd0 && item.request_length <= dds_pkg::MAX_REQUEST)
            items_sent++;
    endtask

    // Stop sending and wait for every expected result
    task automatic wait_for_drain();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.wdata <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        case (index)
            dds_pkg::REG_ACTIVE_SLOT: run_slot = value[0];
            dds_pkg::REG_SLOT_A_BASE: a_base   = value;
            dds_pkg::REG_SLOT_A_CAP:  a_cap    = value;
            dds_pkg::REG_SLOT_B_BASE: b_base   = value;
            dds_pkg::REG_SLOT_B_CAP:  b_cap    = value;
            dds_pkg::REG_SEC_MASK:    key_mask = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic program_slots(input logic active, input logic [31:0] base_a,
                                 input logic [31:0] cap_a, input logic [31:0] base_b,
                                 input logic [31:0] cap_b, input logic [31:0] mask);
        wait_for_drain();
        write_register(dds_pkg::REG_ACTIVE_SLOT, {31'h0, active});
        write_register(dds_pkg::REG_SLOT_A_BASE, base_a);
        write_register(dds_pkg::REG_SLOT_A_CAP, cap_a);
        write_register(dds_pkg::REG_SLOT_B_BASE, base_b);
        write_register(dds_pkg::REG_SLOT_B_CAP, cap_b);
        write_register(dds_pkg::REG_SEC_MASK, mask);
    endtask

    // Request with the given header and random filler elsewhere
    function automatic dds_pkg::req_t request_of(input logic [7:0] sid, input logic [7:0] sub,
                                                 input logic [9:0] len);
        dds_pkg::req_t r;
        r.service_id     = sid;
        r.sub_function   = sub;
        r.format_byte    = 8'($urandom_range(0, 255));
        r.key_value      = $urandom;
        r.download_size  = $urandom;
        r.request_length = len;
        r.tick_count     = $urandom;
        r.flash_ok       = 1'b1;
        return r;
    endfunction

    function automatic dds_pkg::req_t random_request();
        dds_pkg::req_t r;
        int unsigned   roll;
        r = request_of(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 10'd0);
        case ($urandom_range(0, 7))
            0: r.service_id = dds_pkg::SID_SESSION;
            1: r.service_id = dds_pkg::SID_SECURITY;
            2: r.service_id = dds_pkg::SID_DOWNLOAD;
            3: r.service_id = dds_pkg::SID_TRANSFER;
            4: r.service_id = dds_pkg::SID_EXIT;
            default: ;
        endcase
        if ($urandom_range(0, 1) != 0)
            r.sub_function = 8'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 30)
            r.format_byte = dds_pkg::FMT_ADDR_LEN;
        roll = $urandom_range(0, 99);
        if (roll < 10)
            r.request_length = 10'd0;
        else if (roll < 20)
            r.request_length = 10'($urandom_range(513, 1023));
        else if (roll < 40)
            r.request_length = 10'($urandom_range(1, 512));
        else
            r.request_length = 10'($urandom_range(1, 12));
        r.flash_ok = 1'($urandom_range(0, 1));
        return r;
    endfunction

    task automatic send_plain(input logic [7:0] sid, input logic [7:0] sub,
                              input logic [9:0] len);
        send_request(request_of(sid, sub, len));
    endtask

    task automatic send_seed(input logic [31:0] tick);
        dds_pkg::req_t r;
        r = request_of(dds_pkg::SID_SECURITY, dds_pkg::SUB_REQUEST_SEED,
                       10'($urandom_range(2, 8)));
        r.tick_count = tick;
        send_request(r);
    endtask

    task automatic send_key(input logic [9:0] len, input logic [31:0] key);
        dds_pkg::req_t r;
        r = request_of(dds_pkg::SID_SECURITY, dds_pkg::SUB_SEND_KEY, len);
        r.key_value = key;
        send_request(r);
    endtask

    task automatic send_download(input logic [7:0] sub, input logic [7:0] fmt,
                                 input logic [9:0] len, input logic [31:0] size,
                                 input logic ok);
        dds_pkg::req_t r;
        r = request_of(dds_pkg::SID_DOWNLOAD, sub, len);
        r.format_byte   = fmt;
        r.download_size = size;
        r.flash_ok      = ok;
        send_request(r);
    endtask

    task automatic send_chunk(input logic [7:0] block, input logic [9:0] data_len,
                              input logic ok);
        dds_pkg::req_t r;
        r = request_of(dds_pkg::SID_TRANSFER, block, data_len + 10'd2);
        r.flash_ok = ok;
        send_request(r);
    endtask

    task automatic send_exit(input logic ok);
        dds_pkg::req_t r;
        r = request_of(dds_pkg::SID_EXIT, 8'($urandom_range(0, 255)),
                       10'($urandom_range(1, 4)));
        r.flash_ok = ok;
        send_request(r);
    endtask

    task automatic unlock_session(input logic [31:0] tick);
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_EXTENDED_SESSION, 10'd2);
        send_seed(tick);
        send_key(10'd6, seed_word ^ key_mask);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 99) < 8)
            send_request(random_request());
    endtask

    function automatic logic [9:0] pick_chunk_len();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 10'd0;
        if (roll < 10)
            return 10'(dds_pkg::MAX_CHUNK);
        if (roll < 20)
            return 10'($urandom_range(dds_pkg::MAX_CHUNK + 1, dds_pkg::MAX_REQUEST - 2));
        return 10'($urandom_range(1, dds_pkg::MAX_CHUNK));
    endfunction

    // One download attempt with random content and occasional breakage
    task automatic random_session();
        logic [31:0] cap;
        logic [31:0] size;
        int unsigned roll;
        int unsigned n_chunks;
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_EXTENDED_SESSION,
                   10'($urandom_range(2, 6)));
        maybe_noise();
        send_seed($urandom);
        maybe_noise();
        if ($urandom_range(0, 99) < 85)
            send_key(10'($urandom_range(6, 10)), seed_word ^ key_mask);
        else
            send_key(10'($urandom_range(2, 10)), $urandom);
        if (session_code != dds_pkg::ST_UNLOCKED)
            return;
        cap  = run_slot ? a_cap : b_cap;
        roll = $urandom_range(0, 99);
        if (cap == 32'd0)
            size = $urandom;
        else if (roll < 5)
            size = 32'd0;
        else if (roll < 10)
            size = cap + 32'd1;
        else if (roll < 20)
            size = cap;
        else
            size = $urandom_range(1, cap);
        if ($urandom_range(0, 99) < 85)
            send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN,
                          ($urandom_range(0, 99) < 80) ? 10'd11 : 10'($urandom_range(12, 40)),
                          size, $urandom_range(0, 99) < 90);
        else
            send_download(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                          10'($urandom_range(1, 20)), size, 1'($urandom_range(0, 1)));
        n_chunks = $urandom_range(1, 8);
        repeat (n_chunks)
        begin
            if (session_code != dds_pkg::ST_DOWNLOADING)
                return;
            if ($urandom_range(0, 99) < 95)
                send_chunk(next_block_no, pick_chunk_len(), $urandom_range(0, 99) < 95);
            else
                send_chunk(next_block_no + 8'($urandom_range(1, 255)), pick_chunk_len(), 1'b1);
            maybe_noise();
        end
        if (session_code == dds_pkg::ST_DOWNLOADING)
            send_exit($urandom_range(0, 99) < 90);
    endtask

    task automatic run_sessions(input int unsigned end_count);
        int unsigned roll;
        while (items_sent < end_count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 85)
                random_session();
            else if (roll < 96)
                repeat ($urandom_range(1, 5)) send_request(random_request());
            else
                wait_for_drain();
        end
    endtask

    // Framing: empty, oversized, unknown service, short and bad session requests
    task automatic test_request_framing();
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_EXTENDED_SESSION, 10'd0);
        send_plain(dds_pkg::SID_EXIT, dds_pkg::SUB_NONE, 10'(dds_pkg::MAX_REQUEST + 1));
        send_plain(SID_UNKNOWN, 8'($urandom_range(0, 255)), 10'd4);
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_EXTENDED_SESSION, 10'd1);
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_NONE, 10'd2);
    endtask

    // Protected services refused in the default session
    task automatic test_state_guards();
        send_plain(dds_pkg::SID_SECURITY, dds_pkg::SUB_REQUEST_SEED, 10'd2);
        send_plain(dds_pkg::SID_EXIT, dds_pkg::SUB_NONE, 10'd1);
    endtask

    // Seed and key: no seed, short key, wrong key, seeds from extreme tick counts, good key
    task automatic test_security_access();
        send_plain(dds_pkg::SID_SESSION, dds_pkg::SUB_EXTENDED_SESSION, 10'd2);
        send_key(10'd6, $urandom);
        send_seed(32'h0);
        send_key(10'd5, seed_word ^ key_mask);
        send_key(10'd6, ~(seed_word ^ key_mask));
        send_seed(32'hFFFF_FFFF);
        send_key(10'd6, seed_word ^ key_mask);
    endtask

    // Download refusals, erase failure, chunk cases and a clean exit
    task automatic test_download_flow();
        send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN + 8'd1, 10'd11, 32'd4096, 1'b1);
        send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN, 10'd11, b_cap + 32'd1, 1'b1);
        send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN, 10'd11, b_cap, 1'b0);
        send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN, 10'd11, b_cap, 1'b1);
        send_chunk(next_block_no + 8'd1, 10'd8, 1'b1);
        send_chunk(next_block_no, 10'(dds_pkg::MAX_CHUNK + 1), 1'b1);
        send_chunk(next_block_no, 10'd0, 1'b1);
        send_chunk(next_block_no, 10'(dds_pkg::MAX_CHUNK), 1'b1);
        send_chunk(next_block_no, 10'd5, 1'b0);
        send_exit(1'b1);
    endtask

    // Block counter wrap and flash address wrap in one long download
    task automatic test_block_wrap();
        program_slots(1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        unlock_session($urandom);
        send_download(dds_pkg::SUB_NONE, dds_pkg::FMT_ADDR_LEN, 10'd11, 32'd1, 1'b1);
        repeat (258) send_chunk(next_block_no, 10'($urandom_range(1, 16)), 1'b1);
        send_exit(1'b1);
    endtask

    // Random sessions under several register settings
    task automatic test_random_traffic();
        int unsigned start;
        start = items_sent;
        program_slots(1'b0, $urandom, dds_pkg::RST_SLOT_A_CAP, $urandom,
                      dds_pkg::RST_SLOT_B_CAP, dds_pkg::RST_SEC_MASK);
        run_sessions(start + RANDOM_ITEMS * 12 / 45);
        program_slots(1'b1, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0);
        run_sessions(start + RANDOM_ITEMS * 22 / 45);
        // no idling on either side for this stretch
        program_slots(1'b0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF);
        steady_flow = 1'b1;
        run_sessions(start + RANDOM_ITEMS * 30 / 45);
        steady_flow = 1'b0;
        program_slots(1'($urandom_range(0, 1)), $urandom, $urandom_range(1, 4096), $urandom,
                      $urandom, $urandom);
        run_sessions(start + RANDOM_ITEMS * 42 / 45);
        // slot A holds nothing: every download that reaches the size check is refused on size
        program_slots(1'b1, $urandom, 32'h0, $urandom, $urandom, $urandom);
        run_sessions(start + RANDOM_ITEMS);
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.data    = '0;
        rsp_ch.ready   = 1'b0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = dds_pkg::REG_ACTIVE_SLOT;
        cfg_ch.wdata   = '0;
        items_sent     = 0;
        mismatch_count = 0;
        idle_cycles    = 0;
        stall_left     = 0;
        steady_flow    = 1'b0;
        run_slot       = 1'b0;
        a_base         = '0;
        a_cap          = dds_pkg::RST_SLOT_A_CAP;
        b_base         = '0;
        b_cap          = dds_pkg::RST_SLOT_B_CAP;
        key_mask       = dds_pkg::RST_SEC_MASK;
        clear_session();

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        test_request_framing();
        test_state_guards();
        test_security_access();
        test_download_flow();
        test_block_wrap();
        test_random_traffic();

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_replies.size() == 0)
            $display("** diagnostic_download_server: PASSED **");
        else
            $display("** diagnostic_download_server: FAILED **");
        $finish;
    end

endmodule
